[hdl/mutb_pkg.sv]
// shared types and constants for the metered usage time bucket block
`timescale 1ns / 1ps

package mutb_pkg;

    localparam int DATA_W     = 32;
    localparam int AGE_W      = 8;
    localparam int HOUR_SLOTS = 24;
    localparam int DAY_SLOTS  = 31;
    localparam int HOUR_W     = $clog2(HOUR_SLOTS);
    localparam int DAY_W      = $clog2(DAY_SLOTS);
    localparam int SLOT_W     = (HOUR_W > DAY_W) ? HOUR_W : DAY_W;
    localparam int AGE_DW     = AGE_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_CW     = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] HOUR_PERIOD_RST = DATA_W'(3600000);
    localparam logic [DATA_W-1:0] DAY_PERIOD_RST  = DATA_W'(86400000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOUR_PERIOD = 1'b0,
        CFG_DAY_PERIOD  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } t_div_rsp;

endpackage

[hdl/mutb_if.sv]
// channel interfaces: reading input, result output, configuration writes
`timescale 1ns / 1ps

interface mutb_in_if import mutb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] now_ms;
    logic              reading_valid;
    logic [DATA_W-1:0] total_milli_m3;
    logic [AGE_W-1:0]  hour_age;
    logic [AGE_W-1:0]  day_age;

    modport source (
        output valid, now_ms, reading_valid, total_milli_m3, hour_age, day_age,
        input  ready
    );
    modport sink (
        input  valid, now_ms, reading_valid, total_milli_m3, hour_age, day_age,
        output ready
    );
endinterface

interface mutb_out_if import mutb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] hour_usage;
    logic [DATA_W-1:0] day_usage;
    logic [DATA_W-1:0] today_usage;
    logic [DATA_W-1:0] hours_window_total;
    logic [DATA_W-1:0] days_window_total;

    modport source (
        output valid, hour_usage, day_usage, today_usage, hours_window_total,
               days_window_total,
        input  ready
    );
    modport sink (
        input  valid, hour_usage, day_usage, today_usage, hours_window_total,
               days_window_total,
        output ready
    );
endinterface

interface mutb_cfg_if import mutb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/mutb_div.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mutb_div import mutb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvs, n_dvs;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DATA_W-2:0], ge};
            n_rem = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            n_cnt = r_cnt + DIV_CW'(1);
            if (r_cnt == DIV_CW'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[hdl/mutb_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module mutb_ram #(
    parameter int DEPTH  = 24,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/metered_usage_time_buckets.sv]
// metered usage time buckets: hour and day usage rings fed by cumulative meter totals
// i_in carries one meter reading per transaction (valid/ready); o_out returns exactly
// one result transaction per reading; i_cfg writes the hour (index 0) and day (index 1)
// period registers and is always ready, writes are expected only while idle.
// a reading with reading_valid low only reports: it reads the aged buckets, then today's bucket, then the result.
// a valid reading runs the shared divider once per ring to count elapsed periods,
// then rotates each ring: a read and a write step per elapsed period while the count
// is below the ring size, else the whole ring is cleared at once.
// the block takes one reading at a time; i_in.ready is high only between readings.
// a finished result sits in the output register until taken, and the next reading may be
// accepted meanwhile; it then waits at its last step while the receiver stalls.
// reset (synchronous, active low) empties both rings through per-entry valid bits,
// zeroes slots, period starts, sums and baseline, and loads the default periods.
`timescale 1ns / 1ps

module metered_usage_time_buckets import mutb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mutb_in_if.sink    i_in,
    mutb_out_if.source o_out,
    mutb_cfg_if.sink   i_cfg
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_DIV       = 12'b000000000010,
        S_DIVW      = 12'b000000000100,
        S_STEP_RD   = 12'b000000001000,
        S_STEP_WR   = 12'b000000010000,
        S_RING_END  = 12'b000000100000,
        S_USAGE     = 12'b000001000000,
        S_ADD       = 12'b000010000000,
        S_RD_AGE    = 12'b000100000000,
        S_RD_TODAY  = 12'b001000000000,
        S_CAP_TODAY = 12'b010000000000,
        S_DONE      = 12'b100000000000
    } t_state;

    typedef enum logic {
        RING_HOUR = 1'b0,
        RING_DAY  = 1'b1
    } t_ring;

    t_state            r_state, n_state;
    t_ring             r_ring, n_ring;
    logic [DATA_W-1:0] r_now, n_now;
    logic [DATA_W-1:0] r_total, n_total;
    logic [AGE_W-1:0]  r_hage, n_hage;
    logic [AGE_W-1:0]  r_dage, n_dage;
    logic [DATA_W-1:0] r_hper, n_hper;
    logic [DATA_W-1:0] r_dper, n_dper;
    logic [DATA_W-1:0] r_hstart, n_hstart;
    logic [DATA_W-1:0] r_dstart, n_dstart;
    logic [HOUR_W-1:0] r_hslot, n_hslot;
    logic [DAY_W-1:0]  r_dslot, n_dslot;
    logic [DATA_W-1:0] r_hsum, n_hsum;
    logic [DATA_W-1:0] r_dsum, n_dsum;
    logic [DATA_W-1:0] r_base, n_base;
    logic              r_known, n_known;
    logic [HOUR_SLOTS-1:0] r_hvld, n_hvld;
    logic [DAY_SLOTS-1:0]  r_dvld, n_dvld;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_delta, n_delta;
    logic              r_hrv, n_hrv;
    logic              r_drv, n_drv;
    logic [DATA_W-1:0] r_hu, n_hu;
    logic [DATA_W-1:0] r_du, n_du;
    logic [DATA_W-1:0] r_td, n_td;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_o_hu, n_o_hu;
    logic [DATA_W-1:0] r_o_du, n_o_du;
    logic [DATA_W-1:0] r_o_td, n_o_td;
    logic [DATA_W-1:0] r_o_hsum, n_o_hsum;
    logic [DATA_W-1:0] r_o_dsum, n_o_dsum;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              h_we, d_we;
    logic [DATA_W-1:0] h_wdata, d_wdata;
    logic [HOUR_W-1:0] h_raddr;
    logic [DAY_W-1:0]  d_raddr;
    logic [DATA_W-1:0] h_rdata, d_rdata;

    logic              cur_hour;
    logic [DATA_W-1:0] cur_start;
    logic [DATA_W-1:0] cur_period;
    logic [DATA_W-1:0] cur_slots;
    logic [HOUR_W-1:0] h_nxt;
    logic [DAY_W-1:0]  d_nxt;
    logic [AGE_DW-1:0] h_ad, h_aw;
    logic [AGE_DW-1:0] d_ad, d_aw;
    logic [HOUR_W-1:0] h_aaddr;
    logic [DAY_W-1:0]  d_aaddr;
    logic              h_age_ok, d_age_ok;
    logic [DATA_W-1:0] h_bucket, d_bucket;

    mutb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mutb_ram #(
        .DEPTH  (HOUR_SLOTS),
        .ADDR_W (HOUR_W),
        .DATA_W (DATA_W)
    ) u_hour_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_hslot),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    mutb_ram #(
        .DEPTH  (DAY_SLOTS),
        .ADDR_W (DAY_W),
        .DATA_W (DATA_W)
    ) u_day_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_dslot),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    assign cur_hour   = (r_ring == RING_HOUR);
    assign cur_start  = cur_hour ? r_hstart : r_dstart;
    assign cur_period = cur_hour ? r_hper : r_dper;
    assign cur_slots  = cur_hour ? DATA_W'(HOUR_SLOTS) : DATA_W'(DAY_SLOTS);

    assign h_nxt = (r_hslot == HOUR_W'(HOUR_SLOTS - 1)) ? '0 : r_hslot + HOUR_W'(1);
    assign d_nxt = (r_dslot == DAY_W'(DAY_SLOTS - 1)) ? '0 : r_dslot + DAY_W'(1);

    assign h_ad     = AGE_DW'(r_hslot) - AGE_DW'(r_hage);
    assign h_aw     = h_ad + AGE_DW'(HOUR_SLOTS);
    assign h_aaddr  = h_ad[AGE_DW-1] ? h_aw[HOUR_W-1:0] : h_ad[HOUR_W-1:0];
    assign h_age_ok = (AGE_DW'(r_hage) < AGE_DW'(HOUR_SLOTS));
    assign d_ad     = AGE_DW'(r_dslot) - AGE_DW'(r_dage);
    assign d_aw     = d_ad + AGE_DW'(DAY_SLOTS);
    assign d_aaddr  = d_ad[AGE_DW-1] ? d_aw[DAY_W-1:0] : d_ad[DAY_W-1:0];
    assign d_age_ok = (AGE_DW'(r_dage) < AGE_DW'(DAY_SLOTS));

    assign h_bucket = r_hrv ? h_rdata : '0;
    assign d_bucket = r_drv ? d_rdata : '0;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state  = r_state;
        n_ring   = r_ring;
        n_now    = r_now;
        n_total  = r_total;
        n_hage   = r_hage;
        n_dage   = r_dage;
        n_hper   = r_hper;
        n_dper   = r_dper;
        n_hstart = r_hstart;
        n_dstart = r_dstart;
        n_hslot  = r_hslot;
        n_dslot  = r_dslot;
        n_hsum   = r_hsum;
        n_dsum   = r_dsum;
        n_base   = r_base;
        n_known  = r_known;
        n_hvld   = r_hvld;
        n_dvld   = r_dvld;
        n_cnt    = r_cnt;
        n_delta  = r_delta;
        n_hrv    = r_hrv;
        n_drv    = r_drv;
        n_hu     = r_hu;
        n_du     = r_du;
        n_td     = r_td;
        n_ovalid = r_ovalid && !o_out.ready;
        n_o_hu   = r_o_hu;
        n_o_du   = r_o_du;
        n_o_td   = r_o_td;
        n_o_hsum = r_o_hsum;
        n_o_dsum = r_o_dsum;

        div_req  = '0;
        h_we     = 1'b0;
        d_we     = 1'b0;
        h_wdata  = '0;
        d_wdata  = '0;
        h_raddr  = r_hslot;
        d_raddr  = r_dslot;

        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_HOUR_PERIOD: n_hper = i_cfg.data;
                CFG_DAY_PERIOD:  n_dper = i_cfg.data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_now   = i_in.now_ms;
                    n_total = i_in.total_milli_m3;
                    n_hage  = i_in.hour_age;
                    n_dage  = i_in.day_age;
                    n_ring  = RING_HOUR;
                    n_state = i_in.reading_valid ? S_DIV : S_RD_AGE;
                end
            end
            S_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_now - cur_start;
                div_req.divisor  = (cur_period == '0) ? DATA_W'(1) : cur_period;
                n_state          = S_DIVW;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient == '0) begin
                        n_state = S_RING_END;
                    end else begin
                        if (cur_hour) begin
                            n_hstart = r_now - div_rsp.remainder;
                        end else begin
                            n_dstart = r_now - div_rsp.remainder;
                        end
                        if (div_rsp.quotient >= cur_slots) begin
                            // an empty ring reads the same from every slot
                            if (cur_hour) begin
                                n_hvld = '0;
                                n_hsum = '0;
                            end else begin
                                n_dvld = '0;
                                n_dsum = '0;
                            end
                            n_state = S_RING_END;
                        end else begin
                            n_cnt   = div_rsp.quotient[SLOT_W-1:0];
                            n_state = S_STEP_RD;
                        end
                    end
                end
            end
            S_STEP_RD: begin
                if (cur_hour) begin
                    n_hslot = h_nxt;
                    h_raddr = h_nxt;
                    n_hrv   = r_hvld[h_nxt];
                end else begin
                    n_dslot = d_nxt;
                    d_raddr = d_nxt;
                    n_drv   = r_dvld[d_nxt];
                end
                n_state = S_STEP_WR;
            end
            S_STEP_WR: begin
                if (cur_hour) begin
                    n_hsum          = r_hsum - h_bucket;
                    n_hvld[r_hslot] = 1'b0;
                end else begin
                    n_dsum          = r_dsum - d_bucket;
                    n_dvld[r_dslot] = 1'b0;
                end
                n_cnt   = r_cnt - SLOT_W'(1);
                n_state = (r_cnt == SLOT_W'(1)) ? S_RING_END : S_STEP_RD;
            end
            S_RING_END: begin
                if (cur_hour) begin
                    n_ring  = RING_DAY;
                    n_state = S_DIV;
                end else begin
                    n_state = S_USAGE;
                end
            end
            S_USAGE: begin
                n_state = S_RD_AGE;
                priority if (!r_known) begin
                    n_base  = r_total;
                    n_known = 1'b1;
                end else if (r_total < r_base) begin
                    n_base = r_total;
                end else if (r_total > r_base) begin
                    n_delta = r_total - r_base;
                    n_base  = r_total;
                    n_hrv   = r_hvld[r_hslot];
                    n_drv   = r_dvld[r_dslot];
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                h_we             = 1'b1;
                d_we             = 1'b1;
                h_wdata          = h_bucket + r_delta;
                d_wdata          = d_bucket + r_delta;
                n_hvld[r_hslot]  = 1'b1;
                n_dvld[r_dslot]  = 1'b1;
                n_hsum           = r_hsum + r_delta;
                n_dsum           = r_dsum + r_delta;
                n_state          = S_RD_AGE;
            end
            S_RD_AGE: begin
                h_raddr = h_aaddr;
                d_raddr = d_aaddr;
                n_hrv   = h_age_ok && r_hvld[h_aaddr];
                n_drv   = d_age_ok && r_dvld[d_aaddr];
                n_state = S_RD_TODAY;
            end
            S_RD_TODAY: begin
                n_hu    = h_bucket;
                n_du    = d_bucket;
                d_raddr = r_dslot;
                n_drv   = r_dvld[r_dslot];
                n_state = S_CAP_TODAY;
            end
            S_CAP_TODAY: begin
                n_td    = d_bucket;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_o_hu   = r_hu;
                    n_o_du   = r_du;
                    n_o_td   = r_td;
                    n_o_hsum = r_hsum;
                    n_o_dsum = r_dsum;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ring   <= RING_HOUR;
            r_hper   <= HOUR_PERIOD_RST;
            r_dper   <= DAY_PERIOD_RST;
            r_hstart <= '0;
            r_dstart <= '0;
            r_hslot  <= '0;
            r_dslot  <= '0;
            r_hsum   <= '0;
            r_dsum   <= '0;
            r_base   <= '0;
            r_known  <= 1'b0;
            r_hvld   <= '0;
            r_dvld   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ring   <= n_ring;
            r_hper   <= n_hper;
            r_dper   <= n_dper;
            r_hstart <= n_hstart;
            r_dstart <= n_dstart;
            r_hslot  <= n_hslot;
            r_dslot  <= n_dslot;
            r_hsum   <= n_hsum;
            r_dsum   <= n_dsum;
            r_base   <= n_base;
            r_known  <= n_known;
            r_hvld   <= n_hvld;
            r_dvld   <= n_dvld;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_now    <= n_now;
        r_total  <= n_total;
        r_hage   <= n_hage;
        r_dage   <= n_dage;
        r_delta  <= n_delta;
        r_hrv    <= n_hrv;
        r_drv    <= n_drv;
        r_hu     <= n_hu;
        r_du     <= n_du;
        r_td     <= n_td;
        r_o_hu   <= n_o_hu;
        r_o_du   <= n_o_du;
        r_o_td   <= n_o_td;
        r_o_hsum <= n_o_hsum;
        r_o_dsum <= n_o_dsum;
    end

    assign o_out.valid              = r_ovalid;
    assign o_out.hour_usage         = r_o_hu;
    assign o_out.day_usage          = r_o_du;
    assign o_out.today_usage        = r_o_td;
    assign o_out.hours_window_total = r_o_hsum;
    assign o_out.days_window_total  = r_o_dsum;

endmodule

[sim/testbench.sv]
// self-checking testbench for the metered usage time bucket block
`timescale 1ns / 1ps

module testbench import mutb_pkg::*; ();

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int MAX_REPORTED    = 10;
    localparam int CFG_SETTLE      = 10;
    localparam int END_SETTLE      = 50;

    typedef struct packed {
        logic [DATA_W-1:0] hour_usage;
        logic [DATA_W-1:0] day_usage;
        logic [DATA_W-1:0] today_usage;
        logic [DATA_W-1:0] hours_window_total;
        logic [DATA_W-1:0] days_window_total;
    } t_usage_report;

    logic i_clk;
    logic i_rst_n;

    mutb_in_if  in_if();
    mutb_out_if out_if();
    mutb_cfg_if cfg_if();

    metered_usage_time_buckets u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state, rings indexed by the period register that paces them
    logic [DATA_W-1:0] period_reg [2];
    logic [DATA_W-1:0] bucket_mem [2][256];
    int unsigned       ring_slot  [2];
    logic [DATA_W-1:0] ring_start [2];
    logic [DATA_W-1:0] ring_sum   [2];
    logic [DATA_W-1:0] baseline_total;
    logic              baseline_known;

    t_usage_report     expected_reports [$];
    int                mismatch_count = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                idle_cycles    = 0;
    logic [DATA_W-1:0] now_cursor     = '0;
    logic [DATA_W-1:0] total_cursor   = '0;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int unsigned ring_slots(t_cfg_idx ring);
        return (ring == CFG_HOUR_PERIOD) ? HOUR_SLOTS : DAY_SLOTS;
    endfunction

    function automatic void advance_ring(t_cfg_idx ring, logic [DATA_W-1:0] now);
        int unsigned         slots;
        int unsigned         i;
        logic [DATA_W-1:0]   period;
        logic [DATA_W-1:0]   diff;
        logic [DATA_W-1:0]   elapsed;
        logic [2*DATA_W-1:0] span;
        slots   = ring_slots(ring);
        period  = (period_reg[ring] == '0) ? DATA_W'(1) : period_reg[ring];
        diff    = now - ring_start[ring];
        elapsed = diff / period;
        if (elapsed == '0) begin
            return;
        end
        span = (2*DATA_W)'(elapsed) * (2*DATA_W)'(period);
        ring_start[ring] = ring_start[ring] + span[DATA_W-1:0];
        if (elapsed >= slots) begin
            for (i = 0; i < slots; i++) begin
                bucket_mem[ring][i] = '0;
            end
            ring_sum[ring]  = '0;
            ring_slot[ring] = (ring_slot[ring] + elapsed % slots) % slots;
        end else begin
            for (i = 0; i < elapsed; i++) begin
                ring_slot[ring] = (ring_slot[ring] + 1) % slots;
                ring_sum[ring]  = ring_sum[ring] - bucket_mem[ring][ring_slot[ring]];
                bucket_mem[ring][ring_slot[ring]] = '0;
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] bucket_at(t_cfg_idx ring, logic [AGE_W-1:0] age);
        int unsigned slots;
        slots = ring_slots(ring);
        if (age >= slots) begin
            return '0;
        end
        return bucket_mem[ring][(ring_slot[ring] + slots - age) % slots];
    endfunction

    function automatic t_usage_report predict_usage(logic [DATA_W-1:0] now, logic valid,
                                                    logic [DATA_W-1:0] total,
                                                    logic [AGE_W-1:0] hage,
                                                    logic [AGE_W-1:0] dage);
        t_usage_report     rpt;
        logic [DATA_W-1:0] rise;
        if (valid) begin
            advance_ring(CFG_HOUR_PERIOD, now);
            advance_ring(CFG_DAY_PERIOD, now);
            if (!baseline_known) begin
                baseline_total = total;
                baseline_known = 1'b1;
            end else if (total < baseline_total) begin
                baseline_total = total;
            end else if (total > baseline_total) begin
                rise = total - baseline_total;
                bucket_mem[CFG_HOUR_PERIOD][ring_slot[CFG_HOUR_PERIOD]] += rise;
                bucket_mem[CFG_DAY_PERIOD][ring_slot[CFG_DAY_PERIOD]]   += rise;
                ring_sum[CFG_HOUR_PERIOD] += rise;
                ring_sum[CFG_DAY_PERIOD]  += rise;
                baseline_total = total;
            end
        end
        rpt.hour_usage         = bucket_at(CFG_HOUR_PERIOD, hage);
        rpt.day_usage          = bucket_at(CFG_DAY_PERIOD, dage);
        rpt.today_usage        = bucket_mem[CFG_DAY_PERIOD][ring_slot[CFG_DAY_PERIOD]];
        rpt.hours_window_total = ring_sum[CFG_HOUR_PERIOD];
        rpt.days_window_total  = ring_sum[CFG_DAY_PERIOD];
        return rpt;
    endfunction

    function automatic void check_field(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
                $display("%s mismatch: expected %0d, got %0d", field, want, got);
            end
        end
    endfunction

    task automatic send_reading(logic [DATA_W-1:0] now, logic valid, logic [DATA_W-1:0] total,
                                logic [AGE_W-1:0] hage, logic [AGE_W-1:0] dage);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.now_ms         <= now;
        in_if.reading_valid  <= valid;
        in_if.total_milli_m3 <= total;
        in_if.hour_age       <= hage;
        in_if.day_age        <= dage;
        do @(posedge i_clk); while (!in_if.ready);
        expected_reports.push_back(predict_usage(now, valid, total, hage, dage));
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic write_period(t_cfg_idx idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        period_reg[idx] = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle(int settle);
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // baseline, rise, equal and falling totals, sum wrap, invalid readings
    task automatic test_usage_accounting();
        send_reading(32'd0,    1'b0, 32'hFFFF_FFFF, 8'd0, 8'd0);
        send_reading(32'd1000, 1'b1, 32'd500,       8'd0, 8'd0);
        send_reading(32'd2000, 1'b1, 32'd1500,      8'd0, 8'd0);
        send_reading(32'd3000, 1'b1, 32'd1500,      8'd0, 8'd0);
        send_reading(32'd4000, 1'b1, 32'd100,       8'd1, 8'd1);
        send_reading(32'd5000, 1'b1, 32'hFFFF_FF00, 8'd0, 8'd0);
        send_reading(32'd6000, 1'b1, 32'd0,         8'd0, 8'd0);
        send_reading(32'd7000, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd0);
        send_reading(32'hFFFF_FFFF, 1'b0, 32'd0,    8'd255, 8'd255);
    endtask

    // single and multiple period steps, full ring clears, time wrap, age range
    task automatic test_ring_rotation();
        send_reading(32'd3600000,    1'b1, 32'd7,  8'd0,  8'd0);
        send_reading(32'd3600001,    1'b1, 32'd20, 8'd1,  8'd0);
        send_reading(32'd86400000,   1'b1, 32'd29, 8'd23, 8'd1);
        send_reading(32'd3456000000, 1'b1, 32'd40, 8'd30, 8'd30);
        send_reading(32'd3456000001, 1'b1, 32'd50, 8'd24, 8'd31);
        send_reading(32'd16,         1'b1, 32'd60, 8'd255, 8'd1);
        send_reading(32'd17,         1'b1, 32'd61, 8'd2,  8'd29);
    endtask

    // zero, one and all-ones periods
    task automatic test_period_extremes();
        wait_idle(CFG_SETTLE);
        write_period(CFG_HOUR_PERIOD, 32'd0);
        write_period(CFG_DAY_PERIOD, 32'd0);
        send_reading(32'd18, 1'b1, 32'd70, 8'd1, 8'd1);
        send_reading(32'd21, 1'b1, 32'd75, 8'd3, 8'd3);
        send_reading(32'd21, 1'b1, 32'd80, 8'd0, 8'd3);
        wait_idle(CFG_SETTLE);
        write_period(CFG_HOUR_PERIOD, 32'hFFFF_FFFF);
        write_period(CFG_DAY_PERIOD, 32'hFFFF_FFFF);
        send_reading(ring_start[CFG_HOUR_PERIOD] - 32'd1, 1'b1, 32'd90,  8'd1, 8'd1);
        send_reading(ring_start[CFG_DAY_PERIOD] - 32'd2,  1'b1, 32'd95,  8'd1, 8'd1);
        wait_idle(CFG_SETTLE);
        write_period(CFG_HOUR_PERIOD, 32'd1);
        write_period(CFG_DAY_PERIOD, 32'd1);
        send_reading(ring_start[CFG_HOUR_PERIOD] + 32'd2,  1'b1, 32'd99,  8'd2, 8'd2);
        send_reading(ring_start[CFG_HOUR_PERIOD] + 32'd32, 1'b1, 32'd120, 8'd0, 8'd30);
        now_cursor   = ring_start[CFG_HOUR_PERIOD];
        total_cursor = 32'd120;
    endtask

    // well-formed reading streams with random time steps, plus noise
    task automatic test_random_traffic();
        int               phase;
        int               item;
        int               pick;
        logic [AGE_W-1:0] hage;
        logic [AGE_W-1:0] dage;
        for (phase = 0; phase < 4; phase++) begin
            wait_idle(CFG_SETTLE);
            unique case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            write_period(CFG_HOUR_PERIOD, $urandom_range(1, 500));
            write_period(CFG_DAY_PERIOD, period_reg[CFG_HOUR_PERIOD] * $urandom_range(2, 40));
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                hage = ($urandom_range(0, 3) == 0) ? AGE_W'($urandom_range(0, 255))
                                                   : AGE_W'($urandom_range(0, HOUR_SLOTS + 1));
                dage = ($urandom_range(0, 3) == 0) ? AGE_W'($urandom_range(0, 255))
                                                   : AGE_W'($urandom_range(0, DAY_SLOTS + 1));
                if ($urandom_range(0, 99) < 12) begin
                    send_reading($urandom, 1'b0, $urandom, hage, dage);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        now_cursor += $urandom_range(0, 2 * period_reg[CFG_HOUR_PERIOD]);
                    end else if (pick < 80) begin
                        now_cursor += $urandom_range(0, 2 * period_reg[CFG_DAY_PERIOD]);
                    end else if (pick < 90) begin
                        now_cursor += period_reg[CFG_DAY_PERIOD] * $urandom_range(20, 40);
                    end else if (pick >= 95) begin
                        now_cursor = $urandom;
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        total_cursor += $urandom_range(1, 5000);
                    end else if (pick >= 80 && pick < 90) begin
                        total_cursor = $urandom_range(0, total_cursor);
                    end else if (pick >= 90) begin
                        total_cursor = $urandom;
                    end
                    send_reading(now_cursor, 1'b1, total_cursor, hage, dage);
                end
            end
        end
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_usage_report want_rpt;
        t_usage_report got_rpt;
        if (out_if.valid && out_if.ready) begin
            got_rpt.hour_usage         = out_if.hour_usage;
            got_rpt.day_usage          = out_if.day_usage;
            got_rpt.today_usage        = out_if.today_usage;
            got_rpt.hours_window_total = out_if.hours_window_total;
            got_rpt.days_window_total  = out_if.days_window_total;
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED) begin
                    $display("unexpected result transaction: %h", got_rpt);
                end
            end else begin
                want_rpt = expected_reports.pop_front();
                check_field("hour_usage", want_rpt.hour_usage, got_rpt.hour_usage);
                check_field("day_usage", want_rpt.day_usage, got_rpt.day_usage);
                check_field("today_usage", want_rpt.today_usage, got_rpt.today_usage);
                check_field("hours_window_total", want_rpt.hours_window_total,
                            got_rpt.hours_window_total);
                check_field("days_window_total", want_rpt.days_window_total,
                            got_rpt.days_window_total);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_if.valid          = 1'b0;
        in_if.now_ms         = '0;
        in_if.reading_valid  = 1'b0;
        in_if.total_milli_m3 = '0;
        in_if.hour_age       = '0;
        in_if.day_age        = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_HOUR_PERIOD;
        cfg_if.data          = '0;
        i_rst_n              = 1'b0;

        period_reg[CFG_HOUR_PERIOD] = HOUR_PERIOD_RST;
        period_reg[CFG_DAY_PERIOD]  = DAY_PERIOD_RST;
        for (int r = 0; r < 2; r++) begin
            for (int s = 0; s < 256; s++) begin
                bucket_mem[r][s] = '0;
            end
            ring_slot[r]  = 0;
            ring_start[r] = '0;
            ring_sum[r]   = '0;
        end
        baseline_total = '0;
        baseline_known = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_usage_accounting();
        test_ring_rotation();
        test_period_extremes();
        test_random_traffic();

        wait_idle(END_SETTLE);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/mutb_pkg.sv
hdl/mutb_if.sv
hdl/mutb_div.sv
hdl/mutb_ram.sv
hdl/metered_usage_time_buckets.sv
sim/testbench.sv
